FILE: sv/ray_box_slab_test_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ray / box slab test.
// Each assertion is sampled on the rising edge of clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_TEST_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_DEFINES_SVH

// Plain property check.
`define RBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication check built on the plain form.
`define RBS_ASSERT_IMPLY(label, ante, cons, msg) \
  `RBS_ASSERT(label, (ante) |-> (cons), msg)

`endif

FILE: sv/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// Types, register indexes and fixed-point helpers for the slab test.
// ----------------------------------------------------------------------------
`default_nettype none

package rbs_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DIFF_W      = DATA_WIDTH + 1;
  localparam int PROD_W      = DIFF_W + DATA_WIDTH;
  localparam int CFG_INDEX_W = 3;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic [CFG_INDEX_W-1:0]       cfg_index_t;

  localparam cfg_index_t REG_BOX_MIN_X = 3'd0;
  localparam cfg_index_t REG_BOX_MIN_Y = 3'd1;
  localparam cfg_index_t REG_BOX_MIN_Z = 3'd2;
  localparam cfg_index_t REG_BOX_MAX_X = 3'd3;
  localparam cfg_index_t REG_BOX_MAX_Y = 3'd4;
  localparam cfg_index_t REG_BOX_MAX_Z = 3'd5;

  localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    data_t origin_x;
    data_t origin_y;
    data_t origin_z;
    data_t inv_dir_x;
    data_t inv_dir_y;
    data_t inv_dir_z;
    data_t t_start;
    data_t t_end;
  } ray_t;

  typedef struct packed {
    logic  hit;
    data_t t_enter;
    data_t t_exit;
  } result_t;

  // Drop the fraction bits of a full product (arithmetic shift, so floor)
  // and clamp to the signed data range.
  function automatic data_t fx_scale(input prod_t p);
    prod_t                          shifted;
    logic [PROD_W-DATA_WIDTH:0]     upper;
    data_t                          res;
    shifted = p >>> FRAC_BITS;
    upper   = shifted[PROD_W-1:DATA_WIDTH-1];
    if ((&upper) || !(|upper)) begin
      res = shifted[DATA_WIDTH-1:0];
    end else if (shifted[PROD_W-1]) begin
      res = DATA_MIN;
    end else begin
      res = DATA_MAX;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: sv/ray_box_slab_test.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Ray against axis-aligned box slab test in signed fixed point.
// ----------------------------------------------------------------------------
//   Channel   Signals                            Direction
//   ray       start, busy, ray                   in
//   result    done, result                       out
//   config    cfg_write, cfg_index, cfg_data     in
//
// One ray is taken in every cycle; busy is high only during reset.
// The result strobe done follows the accepting edge through these registers in order:
// input register, offset, multiply, clamp, then the interval narrowing.
// The depth is set by the per-axis 33 x 32 bit multiplier stage.
// Reset clears the pipeline valid bits and the box registers to zero.
// The receiver cannot stall, so no result is ever held back.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_test (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rbs_pkg::ray_t       ray,
  output logic                done,
  output rbs_pkg::result_t    result,
  input  logic                cfg_write,
  input  rbs_pkg::cfg_index_t cfg_index,
  input  rbs_pkg::data_t      cfg_data
);

  rbs_pkg::data_t   box_min [3];
  rbs_pkg::data_t   box_max [3];

  rbs_pkg::ray_t    ray_q;
  logic [3:0]       stage_valid;
  rbs_pkg::data_t   t_start_d [3];
  rbs_pkg::data_t   t_end_d   [3];

  rbs_pkg::data_t   org     [3];
  rbs_pkg::data_t   inv     [3];
  rbs_pkg::data_t   t_near  [3];
  rbs_pkg::data_t   t_far   [3];

  rbs_pkg::data_t   enter;
  rbs_pkg::data_t   leave;
  rbs_pkg::result_t result_next;
  logic             accept;

  assign busy   = rst;
  assign accept = start && !busy;

  assign org[0] = ray_q.origin_x;
  assign org[1] = ray_q.origin_y;
  assign org[2] = ray_q.origin_z;
  assign inv[0] = ray_q.inv_dir_x;
  assign inv[1] = ray_q.inv_dir_y;
  assign inv[2] = ray_q.inv_dir_z;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbs_slab u_slab (
      .clk      (clk),
      .org      (org[a]),
      .inv      (inv[a]),
      .lo_plane (box_min[a]),
      .hi_plane (box_max[a]),
      .t_near   (t_near[a]),
      .t_far    (t_far[a])
    );
  end

  // Box registers; indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        box_min[i] <= '0;
        box_max[i] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        rbs_pkg::REG_BOX_MIN_X: box_min[0] <= cfg_data;
        rbs_pkg::REG_BOX_MIN_Y: box_min[1] <= cfg_data;
        rbs_pkg::REG_BOX_MIN_Z: box_min[2] <= cfg_data;
        rbs_pkg::REG_BOX_MAX_X: box_max[0] <= cfg_data;
        rbs_pkg::REG_BOX_MAX_Y: box_max[1] <= cfg_data;
        rbs_pkg::REG_BOX_MAX_Z: box_max[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The incoming interval rides alongside the slab stages.
  always_ff @(posedge clk) begin
    if (accept) begin
      ray_q <= ray;
    end
    t_start_d[0] <= ray_q.t_start;
    t_end_d[0]   <= ray_q.t_end;
    for (int i = 1; i < 3; i++) begin
      t_start_d[i] <= t_start_d[i-1];
      t_end_d[i]   <= t_end_d[i-1];
    end
  end

  always_comb begin
    enter = t_start_d[2];
    leave = t_end_d[2];
    for (int i = 0; i < 3; i++) begin
      if (t_near[i] > enter) begin
        enter = t_near[i];
      end
      if (t_far[i] < leave) begin
        leave = t_far[i];
      end
    end
    result_next.hit     = (enter <= leave) && (leave > 0);
    result_next.t_enter = enter;
    result_next.t_exit  = leave;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      done        <= 1'b0;
    end else begin
      stage_valid <= {stage_valid[2:0], accept};
      done        <= stage_valid[3];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid[3]) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rbs_slab.sv
// ----------------------------------------------------------------------------
// rbs_slab
// One axis of the slab test: plane select, offset, scale and clamp.
// Three register stages from the ray inputs to t_near / t_far.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_slab (
  input  logic          clk,
  input  rbs_pkg::data_t org,
  input  rbs_pkg::data_t inv,
  input  rbs_pkg::data_t lo_plane,
  input  rbs_pkg::data_t hi_plane,
  output rbs_pkg::data_t t_near,
  output rbs_pkg::data_t t_far
);

  rbs_pkg::data_t near_p;
  rbs_pkg::data_t far_p;
  rbs_pkg::diff_t near_diff_next;
  rbs_pkg::diff_t far_diff_next;

  rbs_pkg::diff_t near_diff;
  rbs_pkg::diff_t far_diff;
  rbs_pkg::data_t inv_q;
  rbs_pkg::prod_t near_prod;
  rbs_pkg::prod_t far_prod;

  // A negative reciprocal means the ray travels toward the lower bound,
  // so the upper plane is crossed first.
  always_comb begin
    near_p         = inv[rbs_pkg::DATA_WIDTH-1] ? hi_plane : lo_plane;
    far_p          = inv[rbs_pkg::DATA_WIDTH-1] ? lo_plane : hi_plane;
    near_diff_next = rbs_pkg::diff_t'(near_p) - rbs_pkg::diff_t'(org);
    far_diff_next  = rbs_pkg::diff_t'(far_p) - rbs_pkg::diff_t'(org);
  end

  always_ff @(posedge clk) begin
    near_diff <= near_diff_next;
    far_diff  <= far_diff_next;
    inv_q     <= inv;
    near_prod <= rbs_pkg::prod_t'(near_diff) * rbs_pkg::prod_t'(inv_q);
    far_prod  <= rbs_pkg::prod_t'(far_diff) * rbs_pkg::prod_t'(inv_q);
    t_near    <= rbs_pkg::fx_scale(near_prod);
    t_far     <= rbs_pkg::fx_scale(far_prod);
  end

endmodule

`default_nettype wire

FILE: sv/rbs_checker.sv
// ----------------------------------------------------------------------------
// rbs_checker
// Port-level checks on the slab test, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ray_box_slab_test_defines.svh"

module rbs_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input rbs_pkg::ray_t    ray,
  input logic             done,
  input rbs_pkg::result_t result
);

  // Every accepted ray produces exactly one result.
  `RBS_ASSERT_IMPLY(a_accept_gives_done, start && !busy, ##5 done, "accepted ray gave no result")
  `RBS_ASSERT_IMPLY(a_done_has_ray, done, $past(start && !busy, 5), "result without a ray")

  // The interval can only shrink.
  `RBS_ASSERT_IMPLY(a_narrow_only, done, (result.t_enter >= $past(ray.t_start, 5)) && (result.t_exit <= $past(ray.t_end, 5)), "interval grew")

  // A hit needs a nonempty interval that ends ahead of the origin.
  `RBS_ASSERT_IMPLY(a_hit_interval, done && result.hit, (result.t_enter <= result.t_exit) && (result.t_exit > 0), "hit on empty interval")

endmodule

bind ray_box_slab_test rbs_checker u_rbs_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .ray    (ray),
  .done   (done),
  .result (result)
);

`default_nettype wire

FILE: test/ray_box_slab_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_checker
// Watches the ray, result and configuration ports of the slab test. Keeps a
// copy of the box registers, works out the narrowed interval for every ray
// that is taken, and compares each result against the oldest prediction.
// ----------------------------------------------------------------------------
module ray_box_slab_checker
  import rbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  ray_t       ray,
  input  logic       done,
  input  result_t    result,
  input  logic       cfg_write,
  input  cfg_index_t cfg_index,
  input  data_t      cfg_data,
  input  logic       wrap_up,
  output int         fail_count,
  output int         outstanding,
  output int         hit_count
);

  data_t   box_lo [3];
  data_t   box_hi [3];
  result_t interval_q [$];
  result_t want;
  bit      leftover_seen;

  initial begin
    fail_count    = 0;
    outstanding   = 0;
    hit_count     = 0;
    leftover_seen = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  // Crossing parameter of one plane: (plane - origin) * reciprocal, floored
  // by the fraction shift and clamped to the data range.
  function automatic data_t plane_param(input data_t plane, input data_t org,
                                        input data_t inv);
    diff_t offset;
    prod_t full;
    prod_t scaled;
    prod_t top_lim;
    prod_t bot_lim;
    offset  = plane - org;
    full    = offset * inv;
    scaled  = full >>> FRAC_BITS;
    top_lim = DATA_MAX;
    bot_lim = DATA_MIN;
    if (scaled > top_lim) return DATA_MAX;
    if (scaled < bot_lim) return DATA_MIN;
    return scaled[DATA_WIDTH-1:0];
  endfunction

  function automatic result_t narrowed_interval(input ray_t r);
    data_t   org [3];
    data_t   inv [3];
    data_t   enter;
    data_t   leave;
    data_t   t_near;
    data_t   t_far;
    result_t res;
    org   = '{r.origin_x, r.origin_y, r.origin_z};
    inv   = '{r.inv_dir_x, r.inv_dir_y, r.inv_dir_z};
    enter = r.t_start;
    leave = r.t_end;
    for (int a = 0; a < 3; a++) begin
      // A negative reciprocal walks the axis downward, so the upper plane
      // is met first.
      if (inv[a] < 0) begin
        t_near = plane_param(box_hi[a], org[a], inv[a]);
        t_far  = plane_param(box_lo[a], org[a], inv[a]);
      end else begin
        t_near = plane_param(box_lo[a], org[a], inv[a]);
        t_far  = plane_param(box_hi[a], org[a], inv[a]);
      end
      if (t_near > enter) enter = t_near;
      if (t_far < leave) leave = t_far;
    end
    res.hit     = (enter <= leave) && (leave > 0);
    res.t_enter = enter;
    res.t_exit  = leave;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      interval_q.delete();
      for (int a = 0; a < 3; a++) begin
        box_lo[a] = '0;
        box_hi[a] = '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BOX_MIN_X: box_lo[0] = cfg_data;
          REG_BOX_MIN_Y: box_lo[1] = cfg_data;
          REG_BOX_MIN_Z: box_lo[2] = cfg_data;
          REG_BOX_MAX_X: box_hi[0] = cfg_data;
          REG_BOX_MAX_Y: box_hi[1] = cfg_data;
          REG_BOX_MAX_Z: box_hi[2] = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        want = narrowed_interval(ray);
        if (want.hit) hit_count++;
        interval_q.push_back(want);
      end
      if (done) begin
        if (interval_q.size() == 0) begin
          report_mismatch("result transfer with no ray outstanding");
        end else begin
          want = interval_q.pop_front();
          if (result.hit !== want.hit)
            report_mismatch($sformatf("hit got %b want %b", result.hit, want.hit));
          if (result.t_enter !== want.t_enter)
            report_mismatch($sformatf("t_enter got %h want %h",
                                      result.t_enter, want.t_enter));
          if (result.t_exit !== want.t_exit)
            report_mismatch($sformatf("t_exit got %h want %h",
                                      result.t_exit, want.t_exit));
        end
      end
      if (wrap_up && !leftover_seen) begin
        leftover_seen = 1;
        if (interval_q.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", interval_q.size()));
      end
    end
    outstanding = interval_q.size();
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives rays and box settings into the slab test: a directed set covering
// axis-parallel rays, misses, boundary hits, floor rounding and saturation,
// then phases of random rays, each phase under a fresh box.
// ----------------------------------------------------------------------------
module tb;
  import rbs_pkg::*;

  localparam int LATENCY        = 5;
  localparam int IDLE_LIMIT     = 1000;
  localparam int NUM_PHASES     = 7;
  localparam int RAYS_PER_PHASE = 100;
  localparam int QONE           = 1 << FRAC_BITS;
  localparam cfg_index_t BOX_REGS [6] = '{REG_BOX_MIN_X, REG_BOX_MIN_Y, REG_BOX_MIN_Z,
                                          REG_BOX_MAX_X, REG_BOX_MAX_Y, REG_BOX_MAX_Z};
  localparam cfg_index_t FIRST_UNUSED_REG = REG_BOX_MAX_Z + 3'd1;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  ray_t       ray;
  logic       done;
  result_t    result;
  logic       cfg_write;
  cfg_index_t cfg_index;
  data_t      cfg_data;
  logic       wrap_up;

  int    fail_count;
  int    outstanding;
  int    hit_count;
  int    rays_sent    = 0;
  int    box_settings = 0;
  int    idle_cycles  = 0;
  data_t box_plan [6];

  ray_box_slab_test DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .ray       (ray),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ray_box_slab_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .ray         (ray),
    .done        (done),
    .result      (result),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .wrap_up     (wrap_up),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .hit_count   (hit_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic data_t near_value(input int span);
    return data_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic data_t pick_wild();
    case ($urandom_range(0, 7))
      0: return DATA_MIN;
      1: return DATA_MAX;
      2: return '0;
      3: return -1;
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic ray_t mk_ray(input data_t ox, input data_t oy, input data_t oz,
                                  input data_t ix, input data_t iy, input data_t iz,
                                  input data_t ts, input data_t te);
    ray_t r;
    r.origin_x  = ox;
    r.origin_y  = oy;
    r.origin_z  = oz;
    r.inv_dir_x = ix;
    r.inv_dir_y = iy;
    r.inv_dir_z = iz;
    r.t_start   = ts;
    r.t_end     = te;
    return r;
  endfunction

  function automatic ray_t wild_ray();
    return mk_ray(pick_wild(), pick_wild(), pick_wild(), pick_wild(),
                  pick_wild(), pick_wild(), pick_wild(), pick_wild());
  endfunction

  // A plausible ray: origin within 8 units of zero, moderate reciprocal
  // (zero now and then), interval starting near zero.
  function automatic ray_t aimed_ray();
    ray_t  r;
    data_t inv [3];
    for (int a = 0; a < 3; a++) begin
      inv[a] = ($urandom_range(0, 7) == 0) ? data_t'(0) : near_value(4 * QONE);
    end
    r = mk_ray(near_value(8 * QONE), near_value(8 * QONE), near_value(8 * QONE),
               inv[0], inv[1], inv[2],
               $urandom_range(0, 1) ? data_t'(0) : near_value(2 * QONE),
               $urandom_range(0, 1) ? DATA_MAX : data_t'($urandom_range(0, 16 * QONE)));
    return r;
  endfunction

  function automatic int pick_gap(input int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 15);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    endcase
  endfunction

  // Entered and left at a falling edge. With no gap, start stays high so
  // rays go back to back.
  task automatic send_ray(input ray_t r, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    ray   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    rays_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  // Writes box_plan into the six registers, then one write to an unused
  // index that the block must ignore.
  task automatic set_box();
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= BOX_REGS[i];
      cfg_data  <= box_plan[i];
      @(negedge clk);
    end
    cfg_index <= FIRST_UNUSED_REG + cfg_index_t'($urandom_range(0, 1));
    cfg_data  <= data_t'($urandom);
    @(negedge clk);
    cfg_write <= 1'b0;
    box_settings++;
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    ray       = '0;
    cfg_write = 1'b0;
    cfg_index = REG_BOX_MIN_X;
    cfg_data  = '0;
    wrap_up   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Box still at its reset value, a single point at the origin.
    send_ray(mk_ray(-QONE, 0, 0, QONE, QONE, QONE, 0, DATA_MAX), 0);
    send_ray(mk_ray(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX,
                    DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX), $urandom_range(0, 15));
    send_ray(mk_ray(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN,
                    DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN), 0);

    drain();
    box_plan = '{-QONE, -QONE, -QONE, QONE, QONE, QONE};
    set_box();
    // Along +x and -x with zero reciprocals on y and z, then a miss.
    send_ray(mk_ray(-5 * QONE, 0, 0, QONE, 0, 0, 0, DATA_MAX), 0);
    send_ray(mk_ray(5 * QONE, 0, 0, -QONE, 0, 0, 0, DATA_MAX), 0);
    send_ray(mk_ray(-5 * QONE, 5 * QONE, 0, QONE, 0, 0, 0, DATA_MAX), $urandom_range(0, 15));
    // Exit exactly at zero, then entry equal to exit above zero.
    send_ray(mk_ray(QONE, 0, 0, QONE, 0, 0, DATA_MIN, DATA_MAX), 0);
    send_ray(mk_ray(-3 * QONE, 0, 0, QONE, DATA_MAX, DATA_MAX, 0, 2 * QONE), 0);
    // Smallest reciprocals with a remainder, so negative products floor.
    send_ray(mk_ray(1, 1, -1, -1, 1, -1, DATA_MIN, DATA_MAX), $urandom_range(0, 15));
    // Incoming interval already empty.
    send_ray(mk_ray(-5 * QONE, 0, 0, QONE, DATA_MAX, DATA_MAX, 3 * QONE, QONE), 0);
    // Products far outside the data range.
    send_ray(mk_ray(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MAX, DATA_MAX, DATA_MAX,
                    DATA_MIN, DATA_MAX), 0);
    send_ray(mk_ray(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MIN, DATA_MIN, DATA_MIN,
                    DATA_MIN, DATA_MAX), 0);

    // Lower corner above the upper one: planes are used as given.
    drain();
    box_plan = '{QONE, QONE, QONE, -QONE, -QONE, -QONE};
    set_box();
    send_ray(mk_ray(-5 * QONE, 0, 0, QONE, DATA_MAX, DATA_MAX, 0, DATA_MAX), 0);
    send_ray(mk_ray(5 * QONE, 0, 0, -QONE, DATA_MIN, DATA_MIN, 0, DATA_MAX), 0);

    // Widest possible box.
    drain();
    box_plan = '{DATA_MIN, DATA_MIN, DATA_MIN, DATA_MAX, DATA_MAX, DATA_MAX};
    set_box();
    send_ray(mk_ray(0, 0, 0, 1, -1, DATA_MAX, 0, DATA_MAX), 0);
    send_ray(mk_ray(DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX, -1,
                    DATA_MIN, DATA_MAX), $urandom_range(0, 15));
    send_ray(mk_ray(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX,
                    DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX), 0);
    send_ray(mk_ray(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN,
                    DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN), 0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      for (int a = 0; a < 3; a++) begin
        case (p)
          2: begin
            box_plan[a]     = DATA_MIN;
            box_plan[a + 3] = DATA_MAX;
          end
          4: begin
            box_plan[a]     = near_value(4 * QONE);
            box_plan[a + 3] = box_plan[a] - data_t'($urandom_range(0, 4 * QONE));
          end
          5: begin
            box_plan[a]     = pick_wild();
            box_plan[a + 3] = pick_wild();
          end
          default: begin
            box_plan[a]     = near_value(4 * QONE);
            box_plan[a + 3] = box_plan[a] + data_t'($urandom_range(0, 4 * QONE));
          end
        endcase
      end
      set_box();
      for (int n = 0; n < RAYS_PER_PHASE; n++) begin
        send_ray(($urandom_range(0, 4) == 0) ? wild_ray() : aimed_ray(), pick_gap(p % 3));
      end
    end

    drain();
    wrap_up <= 1'b1;
    repeat (2) @(negedge clk);
    $display("Ran %0d rays through %0d box settings (extreme, inverted and random boxes).",
             rays_sent, box_settings);
    $display("%0d of the rays were predicted to hit the box.", hit_count);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
